/* rtl/lsc_pkg.sv */
// Shared constants and types for the LRU set-associative cache tag model.
// No dependencies; imported by lsc_req_if and every rtl module.
package lsc_pkg;

	localparam int ADDR_W     = 64;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd2;

	localparam logic [2:0] SET_BITS_RST    = 3'd0;
	localparam logic [3:0] WAYS_RST        = 4'd1;
	localparam logic [5:0] OFFSET_BITS_RST = 6'd4;

	typedef struct packed {
		logic lookup;   // word accepted: read the set row
		logic commit;   // write back reordered row, load result
	} lsc_ctl_t;

endpackage

/* rtl/lsc_if.sv */
// Valid/ready channel interfaces for the access and result words.
// Depends on lsc_pkg.
interface lsc_req_if import lsc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [ADDR_W-1:0] address;

	modport source (output valid, command, address, input ready);
	modport sink   (input valid, command, address, output ready);
endinterface

interface lsc_rsp_if ();
	logic valid;
	logic ready;
	logic hit;
	logic miss;
	logic eviction;
	logic second_hit;

	modport source (output valid, hit, miss, eviction, second_hit, input ready);
	modport sink   (input valid, hit, miss, eviction, second_hit, output ready);
endinterface

/* rtl/lsc_ctrl.sv */
// Handshake and sequencing FSM: lookup, then commit of one access word.
// Depends on lsc_pkg; drives lsc_dpath through lsc_ctl_t.
module lsc_ctrl import lsc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output lsc_ctl_t ctl
);

	typedef enum logic {ST_IDLE, ST_UPDATE} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready   = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign ctl.lookup = in_valid && in_ready;
	assign ctl.commit = (state_q == ST_UPDATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (out_valid_q && out_ready)
						out_valid_q <= 1'b0;
					if (ctl.lookup)
						state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/lsc_dpath.sv */
// Datapath: config registers, set row memory, tag compare, LRU reorder, result.
// Depends on lsc_pkg; sequenced by lsc_ctrl.
module lsc_dpath import lsc_pkg::*; #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lsc_ctl_t              ctl,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic [CMD_W-1:0]      command,
	input  logic [ADDR_W-1:0]     address,
	output logic                  hit,
	output logic                  miss,
	output logic                  eviction,
	output logic                  second_hit
);

	localparam int SETS   = 1 << MAX_SET_BITS;
	localparam int SET_IW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WCW    = $clog2(MAX_WAYS + 1);
	localparam int POS_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

	typedef struct packed {
		logic [MAX_WAYS-1:0]             valid;
		logic [MAX_WAYS-1:0][ADDR_W-1:0] tags;
	} row_t;

	row_t             mem [SETS];
	logic [SETS-1:0]  row_valid_q;

	logic [2:0]       set_bits_q;
	logic [3:0]       ways_q;
	logic [5:0]       offset_bits_q;

	// lookup side
	logic [2:0]        sb;
	logic [6:0]        tsh;
	logic [ADDR_W-1:0] shifted;
	logic [ADDR_W-1:0] tag_c;
	logic [SET_IW-1:0] set_c;
	logic [WCW-1:0]    w;

	// stage 1 registers
	row_t              row_s1;
	logic              rowv_s1;
	logic [ADDR_W-1:0] tag_s1;
	logic [SET_IW-1:0] set_s1;
	logic              mod_s1;

	// update side
	logic [MAX_WAYS-1:0] v_eff;
	logic                found;
	logic [POS_W-1:0]    pos;
	logic                v_sel;
	logic                match_sel;
	row_t                new_row;

	logic hit_q, miss_q, evict_q, second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= SET_BITS_RST;
			ways_q        <= WAYS_RST;
			offset_bits_q <= OFFSET_BITS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SET_BITS:    set_bits_q    <= cfg_wdata[2:0];
				CFG_WAYS:        ways_q        <= cfg_wdata[3:0];
				CFG_OFFSET_BITS: offset_bits_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		sb = (int'(set_bits_q) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_q;
		if (ways_q == 4'd0)
			w = WCW'(1);
		else if (int'(ways_q) > MAX_WAYS)
			w = WCW'(MAX_WAYS);
		else
			w = WCW'(ways_q);
		tsh     = {1'b0, offset_bits_q} + {4'd0, sb};
		tag_c   = tsh[6] ? '0 : (address >> tsh[5:0]);
		shifted = address >> offset_bits_q;
		set_c   = shifted[SET_IW-1:0] & SET_IW'((1 << sb) - 1);
	end

	always_ff @(posedge clk) begin
		if (ctl.lookup) begin
			row_s1 <= mem[set_c];
			tag_s1 <= tag_c;
			set_s1 <= set_c;
			mod_s1 <= (command == CMD_MODIFY);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rowv_s1 <= 1'b0;
		else if (ctl.lookup)
			rowv_s1 <= row_valid_q[set_c];
	end

	// first invalid or matching way in use, else the last way in use
	always_comb begin
		v_eff = rowv_s1 ? row_s1.valid : '0;
		found = 1'b0;
		pos   = '0;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (!found && (i < int'(w)) &&
			    (!v_eff[i] || (row_s1.tags[i] == tag_s1))) begin
				found = 1'b1;
				pos   = POS_W'(i);
			end
		end
		if (!found)
			pos = POS_W'(w - WCW'(1));
		v_sel     = v_eff[pos];
		match_sel = (row_s1.tags[pos] == tag_s1);
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (i == 0) begin
				new_row.valid[i] = 1'b1;
				new_row.tags[i]  = tag_s1;
			end else if (i <= int'(pos)) begin
				new_row.valid[i] = v_eff[i-1];
				new_row.tags[i]  = row_s1.tags[i-1];
			end else begin
				new_row.valid[i] = v_eff[i];
				new_row.tags[i]  = row_s1.tags[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			mem[set_s1] <= new_row;
			hit_q       <= v_sel && match_sel;
			miss_q      <= !(v_sel && match_sel);
			evict_q     <= v_sel && !match_sel;
			second_q    <= mod_s1;   // store half of a modify always hits
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			row_valid_q <= '0;
		else if (ctl.commit)
			row_valid_q[set_s1] <= 1'b1;
	end

	assign hit        = hit_q;
	assign miss       = miss_q;
	assign eviction   = evict_q;
	assign second_hit = second_q;

endmodule

/* rtl/lru_set_assoc_cache_tag_sim.sv */
// Tag-only set-associative cache with true LRU replacement. Each access word
// (load, store or modify plus byte address) yields one result word: hit, miss,
// eviction, and for a modify the hit of its store half. One set row (all ways'
// tags and valid bits, kept in recency order) is read from the row memory in
// the accept cycle and reordered and written back in the next. A new word is
// taken only after the previous one is written back and while no result word
// waits on a low ready. Per-set valid flops clear at reset, so no clearing pass
// is needed. Configuration writes are to be made only while idle; the block
// does not enforce this. Depends on lsc_pkg, lsc_if, lsc_ctrl and lsc_dpath.
module lru_set_assoc_cache_tag_sim import lsc_pkg::*; #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	lsc_req_if.sink               req,
	lsc_rsp_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	lsc_ctl_t ctl;

	lsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.ctl       (ctl)
	);

	lsc_dpath #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.command    (req.command),
		.address    (req.address),
		.hit        (rsp.hit),
		.miss       (rsp.miss),
		.eviction   (rsp.eviction),
		.second_hit (rsp.second_hit)
	);

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for lru_set_assoc_cache_tag_sim: directed and random access words
// over many cache geometries, checked against an in-bench LRU tag shadow.
// Depends on lsc_pkg, lsc_if and the rtl top level.
module tb_top;
	import lsc_pkg::*;

	localparam int SETS_LOG_MAX = 6;
	localparam int WAYS_MAX     = 8;
	localparam int LINES        = (1 << SETS_LOG_MAX) * WAYS_MAX;

	localparam logic [CMD_W-1:0]     CMD_LOAD   = 2'd0;
	localparam logic [CMD_W-1:0]     CMD_STORE  = 2'd1;
	localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic hit;
		logic miss;
		logic eviction;
		logic second_hit;
	} outcome_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	lsc_req_if access_ch ();
	lsc_rsp_if result_ch ();

	lru_set_assoc_cache_tag_sim #(
		.MAX_SET_BITS(SETS_LOG_MAX),
		.MAX_WAYS    (WAYS_MAX)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (access_ch),
		.rsp      (result_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// shadow of the tag rows, recency order per set, most recent first
	logic [ADDR_W-1:0] shadow_tag [LINES];
	logic              shadow_valid [LINES];
	logic [2:0]        cur_set_bits;
	logic [3:0]        cur_ways;
	logic [5:0]        cur_offset_bits;

	outcome_t pending_outcomes [$];
	outcome_t got_outcome;
	outcome_t want_outcome;

	int errors;
	int results_checked;
	int words_accepted;
	int hit_count;
	int miss_count;
	int evict_count;
	int second_hit_count;
	int geometry_count;
	int gap_pct;
	int stall_pct;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int eff_set_bits();
		return (cur_set_bits > SETS_LOG_MAX) ? SETS_LOG_MAX : int'(cur_set_bits);
	endfunction

	function automatic int eff_ways();
		if (cur_ways == 0)
			return 1;
		return (cur_ways > WAYS_MAX) ? WAYS_MAX : int'(cur_ways);
	endfunction

	// one lookup and LRU update; returns {eviction, miss, hit}
	function automatic logic [2:0] touch_line(logic [63:0] addr);
		int                sb;
		int                w;
		int                ob;
		int                tsh;
		int                base;
		int                pos;
		logic [ADDR_W-1:0] line_tag;
		logic [ADDR_W-1:0] old_tag;
		logic              old_valid;
		sb = eff_set_bits();
		w = eff_ways();
		ob = int'(cur_offset_bits);
		tsh = ob + sb;
		line_tag = (tsh >= 64) ? '0 : (addr >> tsh);
		base = int'((addr >> ob) & ((64'd1 << sb) - 64'd1)) * WAYS_MAX;
		pos = 0;
		while (pos < w && shadow_valid[base + pos] && shadow_tag[base + pos] != line_tag)
			pos++;
		if (pos == w)
			pos = w - 1;
		old_tag = shadow_tag[base + pos];
		old_valid = shadow_valid[base + pos];
		for (; pos > 0; pos--) begin
			shadow_tag[base + pos] = shadow_tag[base + pos - 1];
			shadow_valid[base + pos] = shadow_valid[base + pos - 1];
		end
		shadow_tag[base] = line_tag;
		shadow_valid[base] = 1'b1;
		if (old_valid && old_tag == line_tag)
			return 3'b001;
		return old_valid ? 3'b110 : 3'b010;
	endfunction

	function automatic outcome_t predict_access(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr);
		logic [2:0] first;
		logic [2:0] second;
		outcome_t   o;
		first = touch_line(addr);
		second = 3'b000;
		if (cmd == CMD_MODIFY)
			second = touch_line(addr);
		o.hit = first[0];
		o.miss = first[1];
		o.eviction = first[2];
		o.second_hit = second[0];
		return o;
	endfunction

	// address with chosen tag and set under the current geometry, random offset
	function automatic logic [63:0] make_address(logic [63:0] tag_val, int set_idx);
		int          sb;
		int          ob;
		logic [63:0] a;
		sb = eff_set_bits();
		ob = int'(cur_offset_bits);
		a = rand64() & ((64'd1 << ob) - 64'd1);
		a |= (64'(set_idx) & ((64'd1 << sb) - 64'd1)) << ob;
		if (ob + sb < 64)
			a |= tag_val << (ob + sb);
		return a;
	endfunction

	task automatic report_mismatch(string what, logic got, logic want);
		errors++;
		$display("[%0t] result %0d: %s got %b expected %b", $time, results_checked, what,
			got, want);
	endtask

	// accepted words feed the shadow first, then results are checked in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (access_ch.valid && access_ch.ready) begin
				want_outcome = predict_access(access_ch.command, access_ch.address);
				pending_outcomes.push_back(want_outcome);
				words_accepted++;
				hit_count += want_outcome.hit;
				miss_count += want_outcome.miss;
				evict_count += want_outcome.eviction;
				second_hit_count += want_outcome.second_hit;
			end
			if (result_ch.valid && result_ch.ready) begin
				got_outcome.hit = result_ch.hit;
				got_outcome.miss = result_ch.miss;
				got_outcome.eviction = result_ch.eviction;
				got_outcome.second_hit = result_ch.second_hit;
				if (pending_outcomes.size() == 0) begin
					report_mismatch("result word with none pending", 1'b1, 1'b0);
				end else begin
					want_outcome = pending_outcomes.pop_front();
					if (got_outcome.hit !== want_outcome.hit)
						report_mismatch("hit", got_outcome.hit, want_outcome.hit);
					if (got_outcome.miss !== want_outcome.miss)
						report_mismatch("miss", got_outcome.miss, want_outcome.miss);
					if (got_outcome.eviction !== want_outcome.eviction)
						report_mismatch("eviction", got_outcome.eviction,
							want_outcome.eviction);
					if (got_outcome.second_hit !== want_outcome.second_hit)
						report_mismatch("second_hit", got_outcome.second_hit,
							want_outcome.second_hit);
				end
				results_checked++;
			end
		end
	end

	// result side back-pressure
	initial begin
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	// valid stays high after a word is taken; a random gap or drain_results lowers it
	task automatic send_access(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			access_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		access_ch.valid <= 1'b1;
		access_ch.command <= cmd;
		access_ch.address <= addr;
		@(posedge clk);
		while (!access_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		access_ch.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			CFG_SET_BITS:    cur_set_bits = data[2:0];
			CFG_WAYS:        cur_ways = data[3:0];
			CFG_OFFSET_BITS: cur_offset_bits = data;
			default:         ;
		endcase
	endtask

	task automatic set_geometry(logic [5:0] sb_data, logic [5:0] ways_data, logic [5:0] ob_data);
		drain_results();
		write_reg(CFG_SET_BITS, sb_data);
		write_reg(CFG_WAYS, ways_data);
		write_reg(CFG_OFFSET_BITS, ob_data);
		geometry_count++;
	endtask

	// reset registers: one set, one way, 16-byte lines
	task automatic test_reset_geometry();
		send_access(CMD_LOAD, 64'h0);
		send_access(CMD_LOAD, 64'hF);
		send_access(CMD_STORE, 64'h10);
		send_access(CMD_MODIFY, 64'h20);
		send_access(CMD_UNUSED, 64'h10);
		send_access(CMD_LOAD, '1);
		send_access(CMD_MODIFY, '1);
		send_access(CMD_STORE, 64'h0);
	endtask

	// set_bits and ways above their maxima; nine tags into one set
	task automatic test_full_set_eviction();
		set_geometry(6'd7, 6'd15, 6'd0);
		for (int k = 1; k <= 9; k++)
			send_access(CMD_LOAD, (64'(k) << 6) | 64'd5);
		send_access(CMD_LOAD, (64'd2 << 6) | 64'd5);
		send_access(CMD_MODIFY, (64'd1 << 6) | 64'd5);
	endtask

	// tag shift at or past 64 bits, zero ways
	task automatic test_wide_shift();
		set_geometry(6'd6, 6'd0, 6'd63);
		send_access(CMD_LOAD, 64'h8000_0000_0000_0000);
		send_access(CMD_LOAD, 64'h0);
		send_access(CMD_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF);
		set_geometry(6'd6, 6'd8, 6'd58);
		send_access(CMD_STORE, 64'hFC00_0000_0000_0001);
		send_access(CMD_LOAD, 64'h0400_0000_0000_0000);
	endtask

	task automatic run_phase(int count, bit pause_midway);
		logic [63:0]      tag_pool [16];
		int               pool_n;
		int               set_span;
		int               r;
		logic [CMD_W-1:0] cmd;
		logic [63:0]      addr;
		pool_n = eff_ways() + $urandom_range(0, 4);
		set_span = $urandom_range(1, 4);
		for (int k = 0; k < pool_n; k++)
			tag_pool[k] = rand64();
		for (int k = 0; k < count; k++) begin
			if (pause_midway && k == count / 2)
				drain_results();
			r = $urandom_range(0, 15);
			cmd = (r < 5) ? CMD_LOAD : (r < 9) ? CMD_STORE : (r < 14) ? CMD_MODIFY : CMD_UNUSED;
			if ($urandom_range(0, 99) < 12)
				addr = rand64();
			else
				addr = make_address(tag_pool[$urandom_range(0, pool_n - 1)],
					$urandom_range(0, set_span - 1));
			send_access(cmd, addr);
		end
	endtask

	task automatic test_random_geometries();
		logic [5:0] ob;
		for (int p = 0; p < 11; p++) begin
			case (p)
				0: set_geometry(6'd0, 6'd1, 6'd0);
				1: set_geometry(6'd6, 6'd8, 6'd58);
				2: set_geometry(6'd7, 6'd15, 6'd63);
				3: set_geometry(6'd2, 6'd4, 6'd4);
				4: set_geometry(6'd3, 6'd0, 6'd12);
				default: begin
					ob = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
						: 6'($urandom_range(0, 20));
					set_geometry({3'($urandom), 3'($urandom)},
						{2'($urandom), 4'($urandom)}, ob);
				end
			endcase
			if (p % 3 == 0)
				write_reg(CFG_UNUSED, 6'($urandom));
			gap_pct = (p % 4 == 3) ? 0 : $urandom_range(5, 40);
			stall_pct = (p % 5 == 4) ? 0 : $urandom_range(2, 15);
			run_phase(80, p == 1 || $urandom_range(0, 3) == 0);
		end
	endtask

	task automatic test_quiet_tail();
		set_geometry(6'($urandom_range(0, 6)), 6'($urandom_range(1, 8)),
			6'($urandom_range(0, 8)));
		gap_pct = 0;
		stall_pct = 0;
		run_phase(70, 1'b0);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		access_ch.valid = 1'b0;
		access_ch.command = '0;
		access_ch.address = '0;
		for (int i = 0; i < LINES; i++) begin
			shadow_tag[i] = '0;
			shadow_valid[i] = 1'b0;
		end
		cur_set_bits = SET_BITS_RST;
		cur_ways = WAYS_RST;
		cur_offset_bits = OFFSET_BITS_RST;
		errors = 0;
		results_checked = 0;
		words_accepted = 0;
		hit_count = 0;
		miss_count = 0;
		evict_count = 0;
		second_hit_count = 0;
		geometry_count = 1;
		gap_pct = 20;
		stall_pct = 8;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_geometry();
		test_full_set_eviction();
		test_wide_shift();
		test_random_geometries();
		test_quiet_tail();

		drain_results();
		repeat (8) @(negedge clk);
		$display("%0d access words over %0d register settings, %0d results checked",
			words_accepted, geometry_count, results_checked);
		$display("%0d hits, %0d misses, %0d evictions, %0d modify store hits",
			hit_count, miss_count, evict_count, second_hit_count);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
